// File: sv/efws_pkg.sv
// Shared types and constants for the earliest-free worker scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package efws_pkg;

  localparam int unsigned TimeW          = 48;
  localparam int unsigned DurW           = 32;
  localparam int unsigned CfgW           = 5;
  localparam int unsigned OutIdxW        = 4;
  localparam int unsigned IdxMaxW        = 8;   // holds any worker index up to 255
  localparam int unsigned NumWorkersDef  = 16;
  localparam int unsigned InDataW        = 32;
  localparam int unsigned OutDataW       = 56;  // 4 + 48 bits, padded to whole bytes

  // Running minimum handed from cell to cell.
  typedef struct packed {
    logic               valid;
    logic [TimeW-1:0]   value;
    logic [IdxMaxW-1:0] idx;
  } cand_t;

  // Finish-time update broadcast to all cells.
  typedef struct packed {
    logic               en;
    logic [IdxMaxW-1:0] idx;
    logic [TimeW-1:0]   value;
  } wr_t;

endpackage

`default_nettype wire

// File: sv/earliest_free_worker_scheduler_core.sv
// Earliest-free worker scheduler: one job in, one (worker, start time) out.
// While unused workers remain, a job goes to the next unused worker with
// start time zero; once all are in use, the minimum search runs over the row
// of cells that passes the running minimum one cell per cycle.
// One job at a time: the next job is accepted the cycle after the
// result is loaded.
// Reset (async, active low) zeroes all finish times and sets 1 worker in use.
`default_nettype none

module earliest_free_worker_scheduler_core
  import efws_pkg::*;
#(
  parameter int unsigned NUM_WORKERS = NumWorkersDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: workers_in_use
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i,
  // job input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [31:0] job_duration
  // result output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [3:0] assigned_worker, [51:4] job start
  output logic                m_axis_tuser    // [0] time_saturated
);

  localparam int unsigned CntW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int unsigned EnW  = $clog2(NUM_WORKERS + 1);
  localparam int unsigned CmpW = (EnW > CfgW) ? EnW : CfgW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CfgW-1:0]    cfg_q;
  logic [EnW-1:0]     started_q, started_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [DurW-1:0]    dur_q;
  logic               use_chain_q;
  logic [IdxMaxW-1:0] pick_q;
  logic [EnW-1:0]     n_eff;
  logic               s_fire;
  logic               fin_go;

  cand_t              cand [NUM_WORKERS+1];
  wr_t                wr;

  logic [IdxMaxW-1:0] fin_idx;
  logic [TimeW-1:0]   fin_start;
  logic [TimeW:0]     sum;
  logic               sat;
  logic [IdxMaxW+OutIdxW-1:0] idx_ext;

  logic               out_valid_q;
  logic [OutIdxW-1:0] out_worker_q;
  logic [TimeW-1:0]   out_start_q;
  logic               out_sat_q;

  // Clamp the configured worker count to 1..NUM_WORKERS.
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = EnW'(1);
    end else if (CmpW'(cfg_q) > CmpW'(NUM_WORKERS)) begin
      n_eff = EnW'(NUM_WORKERS);
    end else begin
      n_eff = EnW'(cfg_q);
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgW'(1);
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Row of cells; the last cell's register carries the minimum.
  assign cand[0] = '0;

  for (genvar i = 0; i < NUM_WORKERS; i++) begin : g_cell
    efws_cell #(
      .CellIdx(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (EnW'(i) < n_eff),
      .cand_i (cand[i]),
      .wr_i   (wr),
      .cand_o (cand[i+1])
    );
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign fin_go        = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

  assign fin_idx   = use_chain_q ? cand[NUM_WORKERS].idx   : pick_q;
  assign fin_start = use_chain_q ? cand[NUM_WORKERS].value : '0;
  assign sum       = {1'b0, fin_start} + (TimeW+1)'(dur_q);
  assign sat       = sum[TimeW];
  assign idx_ext   = {{OutIdxW{1'b0}}, fin_idx};

  always_comb begin
    wr.en    = fin_go;
    wr.idx   = fin_idx;
    wr.value = sat ? {TimeW{1'b1}} : sum[TimeW-1:0];
  end

  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    cnt_d     = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          cnt_d = '0;
          if (started_q < n_eff) begin
            started_d = started_q + EnW'(1);
            state_d   = S_FIN;
          end else begin
            state_d   = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        // Wait until the minimum has walked the whole row.
        if (cnt_q == CntW'(NUM_WORKERS - 1)) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      dur_q       <= s_axis_tdata[DurW-1:0];
      use_chain_q <= !(started_q < n_eff);
      pick_q      <= IdxMaxW'(started_q);
    end
    if (fin_go) begin
      out_worker_q <= idx_ext[OutIdxW-1:0];
      out_start_q  <= fin_start;
      out_sat_q    <= sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-OutIdxW-TimeW){1'b0}}, out_start_q, out_worker_q};
  assign m_axis_tuser  = out_sat_q;

endmodule

`default_nettype wire

// File: sv/efws_cell.sv
// One worker cell: holds the worker's finish time and folds it into the
// running minimum passed down the row. Depends on efws_pkg.
`default_nettype none

module efws_cell
  import efws_pkg::*;
#(
  parameter int unsigned CellIdx = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cand_t cand_i,
  input  wr_t   wr_i,
  output cand_t cand_o
);

  logic [TimeW-1:0] time_q;
  cand_t            cand_q;
  cand_t            cand_d;
  logic             take;

  // Strict compare keeps the lower index on a tie.
  assign take = en_i && (!cand_i.valid || (time_q < cand_i.value));

  always_comb begin
    if (take) begin
      cand_d.valid = 1'b1;
      cand_d.value = time_q;
      cand_d.idx   = IdxMaxW'(CellIdx);
    end else begin
      cand_d = cand_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      cand_q <= '0;
    end else begin
      cand_q <= cand_d;
      if (wr_i.en && (wr_i.idx == IdxMaxW'(CellIdx))) begin
        time_q <= wr_i.value;
      end
    end
  end

  assign cand_o = cand_q;

endmodule

`default_nettype wire
